@@ sv/rv32i_instruction_decoder_defines.svh @@
// assertion helpers shared by the checker
// every check runs on i_clk and is off while i_rst_n is low
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// same-cycle implication
`define RVID_CHECK_NOW(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cons)) else $error(msg);

// next-cycle implication
`define RVID_CHECK_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/rvid_pkg.sv @@
package rvid_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_opcode;
    typedef logic [2:0]  t_funct3;
    typedef logic [6:0]  t_funct7;
    typedef logic [5:0]  t_mnemonic;
    typedef logic [4:0]  t_reg_addr;

    // major opcodes
    localparam t_opcode OPC_LOAD   = 7'h03;
    localparam t_opcode OPC_OPIMM  = 7'h13;
    localparam t_opcode OPC_AUIPC  = 7'h17;
    localparam t_opcode OPC_STORE  = 7'h23;
    localparam t_opcode OPC_OP     = 7'h33;
    localparam t_opcode OPC_LUI    = 7'h37;
    localparam t_opcode OPC_BRANCH = 7'h63;
    localparam t_opcode OPC_JALR   = 7'h67;
    localparam t_opcode OPC_JAL    = 7'h6F;

    localparam t_funct7 F7_BASE = 7'h00;
    localparam t_funct7 F7_ALT  = 7'h20;

    localparam t_word UPPER_MASK = 32'hFFFF_F000;

    // funct3 codes
    localparam t_funct3 F3_0 = 3'd0;
    localparam t_funct3 F3_1 = 3'd1;
    localparam t_funct3 F3_2 = 3'd2;
    localparam t_funct3 F3_3 = 3'd3;
    localparam t_funct3 F3_4 = 3'd4;
    localparam t_funct3 F3_5 = 3'd5;
    localparam t_funct3 F3_6 = 3'd6;
    localparam t_funct3 F3_7 = 3'd7;

    // dense mnemonic codes
    localparam t_mnemonic MN_UNKNOWN = 6'd0;
    localparam t_mnemonic MN_LB    = 6'd0;
    localparam t_mnemonic MN_LH    = 6'd1;
    localparam t_mnemonic MN_LW    = 6'd2;
    localparam t_mnemonic MN_LBU   = 6'd3;
    localparam t_mnemonic MN_LHU   = 6'd4;
    localparam t_mnemonic MN_ADDI  = 6'd5;
    localparam t_mnemonic MN_SLLI  = 6'd6;
    localparam t_mnemonic MN_SLTI  = 6'd7;
    localparam t_mnemonic MN_SLTIU = 6'd8;
    localparam t_mnemonic MN_XORI  = 6'd9;
    localparam t_mnemonic MN_SRLI  = 6'd10;
    localparam t_mnemonic MN_SRAI  = 6'd11;
    localparam t_mnemonic MN_ORI   = 6'd12;
    localparam t_mnemonic MN_ANDI  = 6'd13;
    localparam t_mnemonic MN_AUIPC = 6'd14;
    localparam t_mnemonic MN_SB    = 6'd15;
    localparam t_mnemonic MN_SH    = 6'd16;
    localparam t_mnemonic MN_SW    = 6'd17;
    localparam t_mnemonic MN_ADD   = 6'd18;
    localparam t_mnemonic MN_SUB   = 6'd19;
    localparam t_mnemonic MN_SLL   = 6'd20;
    localparam t_mnemonic MN_SLT   = 6'd21;
    localparam t_mnemonic MN_SLTU  = 6'd22;
    localparam t_mnemonic MN_XOR   = 6'd23;
    localparam t_mnemonic MN_SRL   = 6'd24;
    localparam t_mnemonic MN_SRA   = 6'd25;
    localparam t_mnemonic MN_OR    = 6'd26;
    localparam t_mnemonic MN_AND   = 6'd27;
    localparam t_mnemonic MN_LUI   = 6'd28;
    localparam t_mnemonic MN_BEQ   = 6'd29;
    localparam t_mnemonic MN_BNE   = 6'd30;
    localparam t_mnemonic MN_BLT   = 6'd31;
    localparam t_mnemonic MN_BGE   = 6'd32;
    localparam t_mnemonic MN_BLTU  = 6'd33;
    localparam t_mnemonic MN_BGEU  = 6'd34;
    localparam t_mnemonic MN_JALR  = 6'd35;
    localparam t_mnemonic MN_JAL   = 6'd36;
    localparam t_mnemonic MN_LAST  = 6'd36;

    // immediate format
    typedef enum logic [2:0] {
        IMM_NONE  = 3'd0,
        IMM_I     = 3'd1,
        IMM_S     = 3'd2,
        IMM_B     = 3'd3,
        IMM_J     = 3'd4,
        IMM_U     = 3'd5,
        IMM_SHAMT = 3'd6
    } t_imm_fmt;

    typedef struct packed {
        t_mnemonic mnemonic;
        logic      unknown;
        t_imm_fmt  fmt;
    } t_dec_ctl;

endpackage

@@ sv/rvid_if.sv @@
interface rvid_instr_if;
    import rvid_pkg::*;
    logic  valid;
    logic  ready;
    t_word instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvid_decode_if;
    import rvid_pkg::*;
    logic               valid;
    logic               ready;
    t_mnemonic          mnemonic;
    logic               unknown;
    t_reg_addr          dest_reg;
    t_reg_addr          source_reg_one;
    t_reg_addr          source_reg_two;
    logic signed [31:0] immediate;
    modport source (output valid, output mnemonic, output unknown, output dest_reg,
                    output source_reg_one, output source_reg_two, output immediate,
                    input ready);
    modport sink   (input valid, input mnemonic, input unknown, input dest_reg,
                    input source_reg_one, input source_reg_two, input immediate,
                    output ready);
endinterface

@@ sv/rvid_decode.sv @@
module rvid_decode (
    input  rvid_pkg::t_word    i_word,
    output rvid_pkg::t_dec_ctl o_ctl
);
    import rvid_pkg::*;

    t_opcode   opc;
    t_funct3   f3;
    t_funct7   f7;
    logic      alt;
    logic      known;
    t_mnemonic mn;
    t_imm_fmt  fmt;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];
    assign alt = i_word[30];

    always_comb begin
        known = 1'b1;
        mn    = MN_UNKNOWN;
        fmt   = IMM_NONE;
        case (opc)
            OPC_LOAD: begin
                fmt = IMM_I;
                case (f3)
                    F3_0:    mn = MN_LB;
                    F3_1:    mn = MN_LH;
                    F3_2:    mn = MN_LW;
                    F3_4:    mn = MN_LBU;
                    F3_5:    mn = MN_LHU;
                    default: known = 1'b0;
                endcase
            end
            OPC_OPIMM: begin
                fmt = IMM_I;
                case (f3)
                    F3_0:    mn = MN_ADDI;
                    F3_1: begin
                        mn  = MN_SLLI;
                        fmt = IMM_SHAMT;
                    end
                    F3_2:    mn = MN_SLTI;
                    F3_3:    mn = MN_SLTIU;
                    F3_4:    mn = MN_XORI;
                    F3_5: begin
                        mn  = alt ? MN_SRAI : MN_SRLI;
                        fmt = IMM_SHAMT;
                    end
                    F3_6:    mn = MN_ORI;
                    default: mn = MN_ANDI;
                endcase
            end
            OPC_AUIPC: begin
                mn  = MN_AUIPC;
                fmt = IMM_U;
            end
            OPC_STORE: begin
                fmt = IMM_S;
                case (f3)
                    F3_0:    mn = MN_SB;
                    F3_1:    mn = MN_SH;
                    F3_2:    mn = MN_SW;
                    default: known = 1'b0;
                endcase
            end
            OPC_OP: begin
                case (f3)
                    F3_0: begin
                        if (f7 == F7_BASE) begin
                            mn = MN_ADD;
                        end else if (f7 == F7_ALT) begin
                            mn = MN_SUB;
                        end else begin
                            known = 1'b0;
                        end
                    end
                    F3_1:    mn = MN_SLL;
                    F3_2:    mn = MN_SLT;
                    F3_3:    mn = MN_SLTU;
                    F3_4:    mn = MN_XOR;
                    F3_5:    mn = alt ? MN_SRA : MN_SRL;
                    F3_6:    mn = MN_OR;
                    default: mn = MN_AND;
                endcase
            end
            OPC_LUI: begin
                mn  = MN_LUI;
                fmt = IMM_U;
            end
            OPC_BRANCH: begin
                fmt = IMM_B;
                case (f3)
                    F3_0:    mn = MN_BEQ;
                    F3_1:    mn = MN_BNE;
                    F3_4:    mn = MN_BLT;
                    F3_5:    mn = MN_BGE;
                    F3_6:    mn = MN_BLTU;
                    F3_7:    mn = MN_BGEU;
                    default: known = 1'b0;
                endcase
            end
            OPC_JALR: begin
                mn  = MN_JALR;
                fmt = IMM_I;
            end
            OPC_JAL: begin
                mn  = MN_JAL;
                fmt = IMM_J;
            end
            default: known = 1'b0;
        endcase

        // no match: code zero, immediate forced to zero
        if (!known) begin
            mn  = MN_UNKNOWN;
            fmt = IMM_NONE;
        end
    end

    assign o_ctl.mnemonic = mn;
    assign o_ctl.unknown  = !known;
    assign o_ctl.fmt      = fmt;

endmodule

@@ sv/rvid_immgen.sv @@
module rvid_immgen (
    input  rvid_pkg::t_word    i_word,
    input  rvid_pkg::t_imm_fmt i_fmt,
    output logic signed [31:0] o_imm
);
    import rvid_pkg::*;

    always_comb begin
        case (i_fmt)
            IMM_I:     o_imm = {{20{i_word[31]}}, i_word[31:20]};
            IMM_S:     o_imm = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
            IMM_B:     o_imm = {{19{i_word[31]}}, i_word[31], i_word[7],
                                i_word[30:25], i_word[11:8], 1'b0};
            IMM_J:     o_imm = {{11{i_word[31]}}, i_word[31], i_word[19:12],
                                i_word[20], i_word[30:21], 1'b0};
            IMM_U:     o_imm = i_word & UPPER_MASK;
            IMM_SHAMT: o_imm = {27'd0, i_word[24:20]};
            default:   o_imm = '0;
        endcase
    end

endmodule

@@ sv/rv32i_instruction_decoder.sv @@
// a request accepted into stage 1 moves through stage 2 into the output register, where it shows on o_dec
// throughput: one instruction word per cycle while the output is not stalled, set by the three-stage register pipeline
// a stage takes a new word whenever it is empty or the stage after it moves on,
// so a stalled output holds every stage with no empty stage after it in place and nothing is lost or repeated
// reset (i_rst_n low, synchronous) empties all stages; payload registers are not reset
module rv32i_instruction_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rvid_instr_if.sink           i_instr,
    rvid_decode_if.source        o_dec
);
    import rvid_pkg::*;

    // stage 1: captured instruction word
    logic  r_s1_valid, n_s1_valid;
    t_word r_s1_word;

    // stage 2: word plus opcode/funct decode
    logic     r_s2_valid, n_s2_valid;
    t_word    r_s2_word;
    t_dec_ctl r_s2_ctl;

    // stage 3: output register
    logic               r_out_valid, n_out_valid;
    t_mnemonic          r_out_mnemonic;
    logic               r_out_unknown;
    t_reg_addr          r_out_rd;
    t_reg_addr          r_out_rs1;
    t_reg_addr          r_out_rs2;
    logic signed [31:0] r_out_imm;

    // stage move enables, back to front
    logic out_free;
    logic s2_free;
    logic s1_free;

    t_dec_ctl           s1_ctl;
    logic signed [31:0] s2_imm;

    assign out_free = !r_out_valid || o_dec.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;

    assign i_instr.ready = s1_free;

    // opcode and function field decode sits between stage 1 and stage 2
    rvid_decode u_decode (
        .i_word (r_s1_word),
        .o_ctl  (s1_ctl)
    );

    // immediate assembly sits between stage 2 and the output register
    rvid_immgen u_immgen (
        .i_word (r_s2_word),
        .i_fmt  (r_s2_ctl.fmt),
        .o_imm  (s2_imm)
    );

    always_comb begin
        n_s1_valid  = s1_free  ? i_instr.valid : r_s1_valid;
        n_s2_valid  = s2_free  ? r_s1_valid    : r_s2_valid;
        n_out_valid = out_free ? r_s2_valid    : r_out_valid;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, loaded only when the stage moves and its source holds an item
    always_ff @(posedge i_clk) begin
        if (s1_free && i_instr.valid) begin
            r_s1_word <= i_instr.instruction_word;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_word <= r_s1_word;
            r_s2_ctl  <= s1_ctl;
        end
        if (out_free && r_s2_valid) begin
            r_out_mnemonic <= r_s2_ctl.mnemonic;
            r_out_unknown  <= r_s2_ctl.unknown;
            r_out_rd       <= r_s2_word[11:7];
            r_out_rs1      <= r_s2_word[19:15];
            r_out_rs2      <= r_s2_word[24:20];
            r_out_imm      <= s2_imm;
        end
    end

    assign o_dec.valid          = r_out_valid;
    assign o_dec.mnemonic       = r_out_mnemonic;
    assign o_dec.unknown        = r_out_unknown;
    assign o_dec.dest_reg       = r_out_rd;
    assign o_dec.source_reg_one = r_out_rs1;
    assign o_dec.source_reg_two = r_out_rs2;
    assign o_dec.immediate      = r_out_imm;

endmodule

@@ sv/rvid_checker.sv @@
`include "rv32i_instruction_decoder_defines.svh"

module rvid_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input rvid_pkg::t_mnemonic  i_mnemonic,
    input logic                 i_unknown,
    input logic signed [31:0]   i_immediate
);
    import rvid_pkg::*;

    logic in_req;
    assign in_req = i_in_valid && i_in_ready;

    // unknown words carry code zero and no immediate
    `RVID_CHECK_NOW(a_unknown_clean, i_out_valid && i_unknown, (i_mnemonic == MN_UNKNOWN) && (i_immediate == 32'sd0), "unknown result with nonzero code or immediate")

    // mnemonic stays within the dense range
    `RVID_CHECK_NOW(a_mnemonic_range, i_out_valid, i_mnemonic <= MN_LAST, "mnemonic out of range")

    // upper immediates have clear low bits
    `RVID_CHECK_NOW(a_upper_imm, i_out_valid && !i_unknown && ((i_mnemonic == MN_LUI) || (i_mnemonic == MN_AUIPC)), i_immediate[11:0] == 12'd0, "upper immediate with low bits set")

    // stalled result holds
    `RVID_CHECK_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mnemonic) && $stable(i_unknown) && $stable(i_immediate), "stalled result changed")

    // with the output register empty every stage is free, so a request is taken
    `RVID_CHECK_NOW(a_empty_accepts, i_in_valid && !i_out_valid, in_req, "request refused while output empty")

endmodule

bind rv32i_instruction_decoder rvid_checker u_rvid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_instr.valid),
    .i_in_ready  (i_instr.ready),
    .i_out_valid (o_dec.valid),
    .i_out_ready (o_dec.ready),
    .i_mnemonic  (o_dec.mnemonic),
    .i_unknown   (o_dec.unknown),
    .i_immediate (o_dec.immediate)
);

@@ verif/rv32i_instruction_decoder_tb.sv @@
module rv32i_instruction_decoder_tb;
    import rvid_pkg::*;

    localparam int DECODE_LATENCY = 3;
    // far past the longest sender gap and receiver stall that pick_gap can draw, so a correct run never reaches it
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        t_mnemonic          mnemonic;
        logic               unknown;
        t_reg_addr          dest_reg;
        t_reg_addr          source_reg_one;
        t_reg_addr          source_reg_two;
        logic signed [31:0] immediate;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    rvid_instr_if  instr_if ();
    rvid_decode_if dec_if ();

    rv32i_instruction_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_if),
        .o_dec   (dec_if)
    );

    t_decoded expected_decodes[$];
    t_decoded want;
    int       failures    = 0;
    int       idle_cycles = 0;
    bit       moved;

    // chance in percent that a request or a result is held back
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // mostly short holds, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic t_word encode(input t_funct7 f7, input t_reg_addr rs2,
                                     input t_reg_addr rs1, input t_funct3 f3,
                                     input t_reg_addr rd, input t_opcode opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic t_word with_op(input t_word w, input t_opcode opc, input t_funct3 f3);
        return {w[31:15], f3, w[11:7], opc};
    endfunction

    // expected decode of one instruction word
    function automatic t_decoded decode_rv32i(input t_word w);
        t_decoded    d;
        t_opcode     opc;
        t_funct3     f3;
        t_funct7     f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] shamt;
        logic [31:0] imm;
        logic        known;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        shamt = {27'd0, w[24:20]};
        imm   = '0;
        known = 1'b1;
        d.mnemonic = MN_UNKNOWN;
        case (opc)
            OPC_LOAD: begin
                imm = imm_i;
                case (f3)
                    F3_0:    d.mnemonic = MN_LB;
                    F3_1:    d.mnemonic = MN_LH;
                    F3_2:    d.mnemonic = MN_LW;
                    F3_4:    d.mnemonic = MN_LBU;
                    F3_5:    d.mnemonic = MN_LHU;
                    default: known = 1'b0;
                endcase
            end
            OPC_OPIMM: begin
                imm = imm_i;
                case (f3)
                    F3_0: d.mnemonic = MN_ADDI;
                    F3_1: begin
                        d.mnemonic = MN_SLLI;
                        imm = shamt;
                    end
                    F3_2: d.mnemonic = MN_SLTI;
                    F3_3: d.mnemonic = MN_SLTIU;
                    F3_4: d.mnemonic = MN_XORI;
                    F3_5: begin
                        d.mnemonic = w[30] ? MN_SRAI : MN_SRLI;
                        imm = shamt;
                    end
                    F3_6:    d.mnemonic = MN_ORI;
                    default: d.mnemonic = MN_ANDI;
                endcase
            end
            OPC_AUIPC: begin
                d.mnemonic = MN_AUIPC;
                imm = w & UPPER_MASK;
            end
            OPC_STORE: begin
                imm = imm_s;
                case (f3)
                    F3_0:    d.mnemonic = MN_SB;
                    F3_1:    d.mnemonic = MN_SH;
                    F3_2:    d.mnemonic = MN_SW;
                    default: known = 1'b0;
                endcase
            end
            OPC_OP: begin
                // register ops carry no immediate; only add/sub check the whole funct7, srl/sra look at bit 30
                case (f3)
                    F3_0: begin
                        if (f7 == F7_BASE)
                            d.mnemonic = MN_ADD;
                        else if (f7 == F7_ALT)
                            d.mnemonic = MN_SUB;
                        else
                            known = 1'b0;
                    end
                    F3_1:    d.mnemonic = MN_SLL;
                    F3_2:    d.mnemonic = MN_SLT;
                    F3_3:    d.mnemonic = MN_SLTU;
                    F3_4:    d.mnemonic = MN_XOR;
                    F3_5:    d.mnemonic = w[30] ? MN_SRA : MN_SRL;
                    F3_6:    d.mnemonic = MN_OR;
                    default: d.mnemonic = MN_AND;
                endcase
            end
            OPC_LUI: begin
                d.mnemonic = MN_LUI;
                imm = w & UPPER_MASK;
            end
            OPC_BRANCH: begin
                imm = imm_b;
                case (f3)
                    F3_0:    d.mnemonic = MN_BEQ;
                    F3_1:    d.mnemonic = MN_BNE;
                    F3_4:    d.mnemonic = MN_BLT;
                    F3_5:    d.mnemonic = MN_BGE;
                    F3_6:    d.mnemonic = MN_BLTU;
                    F3_7:    d.mnemonic = MN_BGEU;
                    default: known = 1'b0;
                endcase
            end
            OPC_JALR: begin
                d.mnemonic = MN_JALR;
                imm = imm_i;
            end
            OPC_JAL: begin
                d.mnemonic = MN_JAL;
                imm = imm_j;
            end
            default: known = 1'b0;
        endcase
        if (!known) begin
            d.mnemonic = MN_UNKNOWN;
            imm = '0;
        end
        d.unknown        = ~known;
        d.dest_reg       = w[11:7];
        d.source_reg_one = w[19:15];
        d.source_reg_two = w[24:20];
        d.immediate      = imm;
        return d;
    endfunction

    // valid instruction of the given kind with random content elsewhere
    function automatic t_word build_instruction(input t_mnemonic m);
        t_word w;
        w = $urandom();
        case (m)
            MN_LB:    w = with_op(w, OPC_LOAD, F3_0);
            MN_LH:    w = with_op(w, OPC_LOAD, F3_1);
            MN_LW:    w = with_op(w, OPC_LOAD, F3_2);
            MN_LBU:   w = with_op(w, OPC_LOAD, F3_4);
            MN_LHU:   w = with_op(w, OPC_LOAD, F3_5);
            MN_ADDI:  w = with_op(w, OPC_OPIMM, F3_0);
            MN_SLLI:  w = with_op(w, OPC_OPIMM, F3_1);
            MN_SLTI:  w = with_op(w, OPC_OPIMM, F3_2);
            MN_SLTIU: w = with_op(w, OPC_OPIMM, F3_3);
            MN_XORI:  w = with_op(w, OPC_OPIMM, F3_4);
            MN_SRLI: begin
                w = with_op(w, OPC_OPIMM, F3_5);
                w[30] = 1'b0;
            end
            MN_SRAI: begin
                w = with_op(w, OPC_OPIMM, F3_5);
                w[30] = 1'b1;
            end
            MN_ORI:   w = with_op(w, OPC_OPIMM, F3_6);
            MN_ANDI:  w = with_op(w, OPC_OPIMM, F3_7);
            MN_AUIPC: w[6:0] = OPC_AUIPC;
            MN_SB:    w = with_op(w, OPC_STORE, F3_0);
            MN_SH:    w = with_op(w, OPC_STORE, F3_1);
            MN_SW:    w = with_op(w, OPC_STORE, F3_2);
            MN_ADD: begin
                w = with_op(w, OPC_OP, F3_0);
                w[31:25] = F7_BASE;
            end
            MN_SUB: begin
                w = with_op(w, OPC_OP, F3_0);
                w[31:25] = F7_ALT;
            end
            MN_SLL:   w = with_op(w, OPC_OP, F3_1);
            MN_SLT:   w = with_op(w, OPC_OP, F3_2);
            MN_SLTU:  w = with_op(w, OPC_OP, F3_3);
            MN_XOR:   w = with_op(w, OPC_OP, F3_4);
            MN_SRL: begin
                w = with_op(w, OPC_OP, F3_5);
                w[30] = 1'b0;
            end
            MN_SRA: begin
                w = with_op(w, OPC_OP, F3_5);
                w[30] = 1'b1;
            end
            MN_OR:    w = with_op(w, OPC_OP, F3_6);
            MN_AND:   w = with_op(w, OPC_OP, F3_7);
            MN_LUI:   w[6:0] = OPC_LUI;
            MN_BEQ:   w = with_op(w, OPC_BRANCH, F3_0);
            MN_BNE:   w = with_op(w, OPC_BRANCH, F3_1);
            MN_BLT:   w = with_op(w, OPC_BRANCH, F3_4);
            MN_BGE:   w = with_op(w, OPC_BRANCH, F3_5);
            MN_BLTU:  w = with_op(w, OPC_BRANCH, F3_6);
            MN_BGEU:  w = with_op(w, OPC_BRANCH, F3_7);
            MN_JALR:  w[6:0] = OPC_JALR;
            default:  w[6:0] = OPC_JAL;
        endcase
        return w;
    endfunction

    // known opcode with a funct3 or funct7 that has no instruction
    function automatic t_word build_broken();
        t_word   w;
        t_funct7 f7;
        w = $urandom();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(2))
                    0:       w = with_op(w, OPC_LOAD, F3_3);
                    1:       w = with_op(w, OPC_LOAD, F3_6);
                    default: w = with_op(w, OPC_LOAD, F3_7);
                endcase
            end
            1: w = with_op(w, OPC_STORE, t_funct3'($urandom_range(F3_7, F3_3)));
            2: w = with_op(w, OPC_BRANCH, $urandom_range(1) ? F3_2 : F3_3);
            default: begin
                f7 = w[31:25];
                if (f7 == F7_BASE || f7 == F7_ALT)
                    f7 = f7 | 7'h01;
                w = with_op(w, OPC_OP, F3_0);
                w[31:25] = f7;
            end
        endcase
        return w;
    endfunction

    function automatic t_word random_instruction();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return build_instruction(t_mnemonic'($urandom_range(MN_LAST)));
        if (r < 93)
            return build_broken();
        return $urandom();
    endfunction

    // one request; valid stays high afterwards so back-to-back requests need no toggle
    task automatic send_instruction(input t_word w);
        int gap;
        gap = pick_gap(gap_pct);
        if (gap > 0) begin
            instr_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        instr_if.valid            <= 1'b1;
        instr_if.instruction_word <= w;
        @(posedge i_clk);
        while (!instr_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed_corners();
        gap_pct   = 0;
        stall_pct = 0;
        send_instruction(32'h0000_0000);
        send_instruction(32'hFFFF_FFFF);
        // immediate extremes
        send_instruction(encode(7'h3F, 5'h1F, 5'h00, F3_0, 5'h1F, OPC_OPIMM));
        send_instruction(encode(7'h40, 5'h00, 5'h1F, F3_0, 5'h00, OPC_OPIMM));
        send_instruction(encode(7'h7F, 5'h1F, 5'h1F, F3_2, 5'h1F, OPC_LOAD));
        send_instruction(encode(7'h7F, 5'h1F, 5'h1F, F3_2, 5'h1F, OPC_STORE));
        send_instruction(encode(7'h40, 5'h00, 5'h00, F3_0, 5'h00, OPC_BRANCH));
        send_instruction(encode(7'h7F, 5'h1F, 5'h1F, F3_7, 5'h1F, OPC_BRANCH));
        send_instruction(encode(7'h40, 5'h00, 5'h00, F3_0, 5'h00, OPC_JAL));
        send_instruction(encode(7'h3F, 5'h1F, 5'h1F, F3_7, 5'h1F, OPC_JAL));
        // funct3 holes of loads, stores and branches
        send_instruction(encode(7'h00, 5'h00, 5'h00, F3_3, 5'h00, OPC_LOAD));
        send_instruction(encode(7'h7F, 5'h1F, 5'h1F, F3_6, 5'h1F, OPC_LOAD));
        send_instruction(encode(7'h55, 5'h0A, 5'h15, F3_3, 5'h0A, OPC_STORE));
        send_instruction(encode(7'h2A, 5'h15, 5'h0A, F3_2, 5'h15, OPC_BRANCH));
        // funct3 is ignored by upper-immediate and jump forms
        send_instruction(encode(7'h7F, 5'h1F, 5'h1F, F3_7, 5'h1F, OPC_LUI));
        send_instruction(encode(7'h55, 5'h0A, 5'h15, F3_5, 5'h0A, OPC_AUIPC));
        send_instruction(encode(7'h7E, 5'h13, 5'h07, F3_5, 5'h11, OPC_JALR));
        // shift immediates: upper bits unchecked, bit 30 picks arithmetic
        send_instruction(encode(7'h7F, 5'h15, 5'h03, F3_1, 5'h04, OPC_OPIMM));
        send_instruction(encode(F7_ALT, 5'h1F, 5'h1E, F3_5, 5'h01, OPC_OPIMM));
        send_instruction(encode(7'h5F, 5'h0B, 5'h1F, F3_5, 5'h1F, OPC_OPIMM));
        // funct7 of register ops
        send_instruction(encode(F7_BASE, 5'h1F, 5'h1F, F3_0, 5'h1F, OPC_OP));
        send_instruction(encode(F7_ALT, 5'h01, 5'h02, F3_0, 5'h03, OPC_OP));
        send_instruction(encode(7'h01, 5'h04, 5'h05, F3_0, 5'h06, OPC_OP));
        send_instruction(encode(7'h60, 5'h07, 5'h08, F3_0, 5'h09, OPC_OP));
        send_instruction(encode(7'h7F, 5'h1F, 5'h00, F3_5, 5'h1F, OPC_OP));
        send_instruction(encode(7'h5F, 5'h00, 5'h1F, F3_5, 5'h00, OPC_OP));
    endtask

    task automatic test_each_instruction();
        gap_pct   = 20;
        stall_pct = 20;
        repeat (2) begin
            for (int m = 0; m <= MN_LAST; m++)
                send_instruction(build_instruction(t_mnemonic'(m)));
        end
    endtask

    task automatic test_back_to_back();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (300) send_instruction(random_instruction());
    endtask

    task automatic test_random_stream();
        gap_pct   = 30;
        stall_pct = 30;
        repeat (1000) send_instruction(random_instruction());
    endtask

    task automatic test_output_stall();
        gap_pct   = 0;
        stall_pct = 70;
        repeat (250) send_instruction(random_instruction());
    endtask

    task automatic test_sparse_requests();
        gap_pct   = 70;
        stall_pct = 10;
        repeat (200) send_instruction(random_instruction());
    endtask

    task automatic test_noise_words();
        gap_pct   = 25;
        stall_pct = 25;
        repeat (150) send_instruction($urandom_range(1) ? build_broken() : $urandom());
    endtask

    // receiver side: random stalls, changed on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            dec_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            dec_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            dec_if.ready <= 1'b1;
            stall_left = pick_gap(stall_pct);
        end
    end

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (instr_if.valid && instr_if.ready) begin
                expected_decodes.push_back(decode_rv32i(instr_if.instruction_word));
                moved = 1'b1;
            end
            if (dec_if.valid && dec_if.ready) begin
                moved = 1'b1;
                if (expected_decodes.size() == 0) begin
                    $error("decode result with no request outstanding");
                    failures++;
                end else begin
                    want = expected_decodes.pop_front();
                    if (dec_if.mnemonic !== want.mnemonic) begin
                        $error("mnemonic: expected %0d, got %0d", want.mnemonic,
                               dec_if.mnemonic);
                        failures++;
                    end
                    if (dec_if.unknown !== want.unknown) begin
                        $error("unknown: expected %0b, got %0b", want.unknown,
                               dec_if.unknown);
                        failures++;
                    end
                    if (dec_if.dest_reg !== want.dest_reg) begin
                        $error("dest_reg: expected %0d, got %0d", want.dest_reg,
                               dec_if.dest_reg);
                        failures++;
                    end
                    if (dec_if.source_reg_one !== want.source_reg_one) begin
                        $error("source_reg_one: expected %0d, got %0d",
                               want.source_reg_one, dec_if.source_reg_one);
                        failures++;
                    end
                    if (dec_if.source_reg_two !== want.source_reg_two) begin
                        $error("source_reg_two: expected %0d, got %0d",
                               want.source_reg_two, dec_if.source_reg_two);
                        failures++;
                    end
                    if (dec_if.immediate !== want.immediate) begin
                        $error("immediate: expected %0d, got %0d", want.immediate,
                               dec_if.immediate);
                        failures++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                   = 1'b0;
        instr_if.valid            = 1'b0;
        instr_if.instruction_word = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_each_instruction();
        test_back_to_back();
        test_random_stream();
        test_output_stall();
        test_sparse_requests();
        test_noise_words();

        instr_if.valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(posedge i_clk);
        // any extra result out of the pipeline shows up here
        repeat (4 * DECODE_LATENCY) @(posedge i_clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
